### rtl/ytpq_pkg.sv
// Shared types, codes and helpers for the Young tableau priority queue.
// No dependencies; imported by the top level, the checker and the bench.
`default_nettype none

package ytpq_pkg;

  localparam int MaxRowsDef = 8;
  localparam int MaxColsDef = 8;

  localparam int ValW = 32;
  localparam int DimW = 4;
  localparam int CfgIdxW = 2;

  localparam logic [DimW-1:0] DIM_RESET = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COLS = 2'd1;

  // command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic            full;
    logic [ValW-1:0] val;
  } cell_t;

  // a orders strictly above b; an empty cell is above every value
  function automatic logic cell_gt(input cell_t a, input cell_t b);
    logic res;
    if (!a.full) begin
      res = b.full;
    end else if (!b.full) begin
      res = 1'b0;
    end else begin
      res = ($signed(a.val) > $signed(b.val));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/ytpq_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module ytpq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

### rtl/young_tableau_priority_queue_top.sv
// Young tableau priority queue: sequencer around one cell RAM.
// Depends on ytpq_pkg and ytpq_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o | command_i, insert_value_i
//  out     | out       | out_valid_o/out_ready_i| status_o, min_value_o
//
// One request at a time: accept, look at the head cell (bottom-right for insert,
// top-left for extract), then one sift step per cycle plus a final write-back step,
// then hand the response to the output register. A refused insert or an empty
// extract skips the sift. Each sift step over the cell RAM makes two neighbor
// reads and one write. After reset the RAM is swept empty, one cell a cycle,
// with in_ready_o low. Configuration writes are taken only while no request is
// in flight (sweep or idle) and win over a request offered in the same cycle.
// A response waiting in the output register does not stop the next request;
// that request then waits in its response cycle until the register drains.
`default_nettype none

module young_tableau_priority_queue_top
  import ytpq_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DimW-1:0]    cfg_data_i,
  // requests
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [ValW-1:0]    insert_value_i,
  // responses
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [ValW-1:0]         min_value_o
);

  localparam int Cells = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HEAD  = 5'b00100,
    S_STEP  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [DimW-1:0] rows_q, cols_q;
  logic [RW-1:0]   rows_last;
  logic [CW-1:0]   cols_last;

  // request context
  logic            cmd_q, cmd_d;
  logic [ValW-1:0] cur_q, cur_d;   // insert value being sifted up
  logic [1:0]      stat_q, stat_d;
  logic [ValW-1:0] minv_q, minv_d;
  logic [RW-1:0]   r_q, r_d;
  logic [CW-1:0]   c_q, c_d;

  // output register
  logic            out_valid_q;
  logic [1:0]      out_stat_q;
  logic [ValW-1:0] out_min_q;

  // RAM side
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  cell_t         wdata, rd_a, rd_b;

  // step evaluation
  cell_t h_cell, pick;
  logic  ok_a, ok_b, ins;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // vertical neighbor: above for insert, below for extract (held at the edge)
  function automatic logic [RW-1:0] nbr_row(input logic [RW-1:0] r, input logic up,
                                            input logic [RW-1:0] last);
    logic [RW-1:0] res;
    if (up) begin
      res = (r == '0) ? r : r - RW'(1);
    end else begin
      res = (r < last) ? r + RW'(1) : r;
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] nbr_col(input logic [CW-1:0] c, input logic up,
                                            input logic [CW-1:0] last);
    logic [CW-1:0] res;
    if (up) begin
      res = (c == '0) ? c : c - CW'(1);
    end else begin
      res = (c < last) ? c + CW'(1) : c;
    end
    return res;
  endfunction

  // clamp the region registers to 1..MAX
  always_comb begin
    if (rows_q == '0) begin
      rows_last = '0;
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(int'(rows_q) - 1);
    end
    if (cols_q == '0) begin
      cols_last = '0;
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(int'(cols_q) - 1);
    end
  end

  // config: ready only while no request is in flight
  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a pending config write goes first
  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign ins        = (cmd_q == CMD_INSERT);

  // insert carries a full cell up; extract carries the empty cell down
  always_comb begin
    h_cell.full = ins;
    h_cell.val  = ins ? cur_q : '0;
    if (ins) begin
      ok_a = (r_q != '0) && cell_gt(rd_a, h_cell);
    end else begin
      ok_a = (r_q < rows_last) && cell_gt(h_cell, rd_a);
    end
    pick = ok_a ? rd_a : h_cell;
    if (ins) begin
      ok_b = (c_q != '0) && cell_gt(rd_b, pick);
    end else begin
      ok_b = (c_q < cols_last) && cell_gt(pick, rd_b);
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    cur_d   = cur_q;
    stat_d  = stat_q;
    minv_d  = minv_q;
    r_d     = r_q;
    c_d     = c_q;
    we      = 1'b0;
    waddr   = cell_addr(r_q, c_q);
    wdata   = h_cell;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Cells - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_d   = command_i;
          cur_d   = insert_value_i;
          stat_d  = ST_OK;
          minv_d  = '0;
          r_d     = (command_i == CMD_INSERT) ? rows_last : '0;
          c_d     = (command_i == CMD_INSERT) ? cols_last : '0;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        // rd_a holds the head cell; neighbor reads go out this cycle
        if (ins) begin
          if (rd_a.full) begin
            stat_d  = ST_FULL;
            state_d = S_RESP;
          end else begin
            state_d = S_STEP;
          end
        end else begin
          if (!rd_a.full) begin
            stat_d  = ST_EMPTY;
            state_d = S_RESP;
          end else begin
            minv_d  = rd_a.val;
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        // the current cell is never in RAM; write the swapped-in neighbor
        // (or the carried cell when the walk ends) and move on
        we = 1'b1;
        if (ok_b) begin
          wdata = rd_b;
          c_d   = nbr_col(c_q, ins, cols_last);
        end else if (ok_a) begin
          wdata = rd_a;
          r_d   = nbr_row(r_q, ins, rows_last);
        end else begin
          wdata   = h_cell;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // head read at accept, neighbor reads of the next position otherwise
  always_comb begin
    if (state_q == S_IDLE) begin
      raddr_a = cell_addr(r_d, c_d);
      raddr_b = cell_addr(r_d, c_d);
    end else begin
      raddr_a = cell_addr(nbr_row(r_d, ins, rows_last), c_d);
      raddr_b = cell_addr(r_d, nbr_col(c_d, ins, cols_last));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    cur_q  <= cur_d;
    stat_q <= stat_d;
    minv_q <= minv_d;
    r_q    <= r_d;
    c_q    <= c_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_stat_q <= stat_q;
      out_min_q  <= minv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign min_value_o = out_min_q;

  ytpq_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (Cells)
  ) u_cells (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

endmodule

`default_nettype wire

### rtl/ytpq_chk.sv
// Port-level checker for the Young tableau priority queue, bound to the top level.
// Depends on ytpq_pkg.
`default_nettype none

module ytpq_chk
  import ytpq_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic [1:0]      status_o,
  input wire logic [ValW-1:0] min_value_o
);

  // requests accepted but not yet answered
  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(min_value_o))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY))
    else $error("undefined status code");

  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> min_value_o == '0)
    else $error("nonzero minimum on failed request");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("response without a request");

endmodule

bind young_tableau_priority_queue_top ytpq_chk u_ytpq_chk (.*);

`default_nettype wire

### tb/tb_young_tableau_priority_queue_top.sv
// Self-checking bench for young_tableau_priority_queue_top: random and directed requests,
// region resizes, backpressure, checked against an in-bench model of the tableau.
// Depends on ytpq_pkg and the RTL of the queue only.
`timescale 1ns / 100ps

module tb_young_tableau_priority_queue_top;
  import ytpq_pkg::*;

  localparam int GridRows = MaxRowsDef;
  localparam int GridCols = MaxColsDef;
  localparam int NumPhases = 12;
  localparam int ItemsPerPhase = 120;
  localparam int SettleCycles = 24;   // longest request plus margin
  localparam int HoldCycles = 200;    // long receiver hold-off
  localparam int StallLimit = 2000;   // cycles with no handshake at all

  // indexes outside the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    logic            cmd;
    logic [ValW-1:0] value;
  } request_t;

  typedef struct {
    logic [1:0]      status;
    logic [ValW-1:0] min_value;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_ROWS;
  logic [DimW-1:0]    cfg_data_i = '0;

  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = CMD_INSERT;
  logic [ValW-1:0]    insert_value_i = '0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [ValW-1:0]    min_value_o;

  young_tableau_priority_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .insert_value_i (insert_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .min_value_o    (min_value_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Model of the tableau: one cell per grid slot with an occupied flag,
  // the raw register values, and the replies still owed by the block.
  // ---------------------------------------------------------------------------
  cell_t           grid [GridRows*GridCols];
  logic [DimW-1:0] rows_reg = DIM_RESET;
  logic [DimW-1:0] cols_reg = DIM_RESET;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];

  int src_idle_pct = 9;
  int sink_idle_pct = 61;
  int hold_requests = 0;
  logic sink_held = 1'b0;

  int mismatches = 0;
  int inserts_kept = 0;
  int inserts_refused = 0;
  int mins_taken = 0;
  int empty_pops = 0;
  int settings_used = 1;

  logic [DimW-1:0] rows_plan [NumPhases] =
    '{4'd8, 4'd1, 4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8, 4'd4, 4'd8};
  logic [DimW-1:0] cols_plan [NumPhases] =
    '{4'd8, 4'd1, 4'd8, 4'd1, 4'd5, 4'd0, 4'd9, 4'd2, 4'd7, 4'd8, 4'd6, 4'd8};

  // register value as the block uses it: 0 acts as 1, too large saturates
  function automatic int region_span(input logic [DimW-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // empty cells rank above everything, occupied cells by signed value
  function automatic bit outranks(input cell_t a, input cell_t b);
    if (a.full && b.full) return $signed(a.val) > $signed(b.val);
    return !a.full && b.full;
  endfunction

  function automatic void swap_cells(input int a, input int b);
    cell_t tmp;
    tmp = grid[a];
    grid[a] = grid[b];
    grid[b] = tmp;
  endfunction

  // Apply one accepted request to the model grid and queue the reply it owes.
  function automatic void tableau_apply(input logic cmd, input logic [ValW-1:0] value);
    int rows, cols, r, c, here, pick, pr, pc;
    bit moving;
    reply_t rep;
    rows = region_span(rows_reg, GridRows);
    cols = region_span(cols_reg, GridCols);
    rep.status = ST_OK;
    rep.min_value = '0;
    if (cmd == CMD_INSERT) begin
      here = (rows - 1) * GridCols + (cols - 1);
      if (grid[here].full) begin
        rep.status = ST_FULL;
        inserts_refused++;
      end else begin
        inserts_kept++;
        grid[here].full = 1'b1;
        grid[here].val = value;
        // climb toward the corner: above first, left wins if strictly larger
        r = rows - 1;
        c = cols - 1;
        moving = 1'b1;
        while (moving) begin
          here = r * GridCols + c;
          pick = here;
          pr = r;
          pc = c;
          if (r > 0 && outranks(grid[here - GridCols], grid[here])) begin
            pick = here - GridCols;
            pr = r - 1;
          end
          if (c > 0 && outranks(grid[here - 1], grid[pick])) begin
            pick = here - 1;
            pr = r;
            pc = c - 1;
          end
          moving = (pick != here);
          if (moving) begin
            swap_cells(pick, here);
            r = pr;
            c = pc;
          end
        end
      end
    end else if (!grid[0].full) begin
      rep.status = ST_EMPTY;
      empty_pops++;
    end else begin
      mins_taken++;
      rep.min_value = grid[0].val;
      grid[0].full = 1'b0;
      grid[0].val = '0;
      // push the hole down/right; a tie goes to the cell below
      r = 0;
      c = 0;
      moving = 1'b1;
      while (moving) begin
        here = r * GridCols + c;
        pick = here;
        pr = r;
        pc = c;
        if (r + 1 < rows && outranks(grid[here], grid[here + GridCols])) begin
          pick = here + GridCols;
          pr = r + 1;
        end
        if (c + 1 < cols && outranks(grid[pick], grid[here + 1])) begin
          pick = here + 1;
          pr = r;
          pc = c + 1;
        end
        moving = (pick != here);
        if (moving) begin
          swap_cells(pick, here);
          r = pr;
          c = pc;
        end
      end
    end
    expected_replies = {expected_replies, rep};
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: holds each request until taken, then pulls the next one
  // from the pending queue unless it decides to idle this cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= CMD_INSERT;
      insert_value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        tableau_apply(command_i, insert_value_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          command_i <= nxt.cmd;
          insert_value_i <= nxt.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: compares every taken response with the oldest reply owed,
  // and throttles out_ready_i.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : response_monitor
    reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] response with none outstanding: status %0d min_value %0d",
                     $time, status_o, $signed(min_value_o));
          end
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status || min_value_o !== want.min_value) begin
            if (mismatches < 10) begin
              $display("[%0t] status exp %0d got %0d | min_value exp %0d got %0d",
                       $time, want.status, status_o,
                       $signed(want.min_value), $signed(min_value_o));
            end
            mismatches++;
          end
        end
      end
      out_ready_i <= !sink_held && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Long receiver hold-off, timed here so the driver keeps offering requests
  // and the block backs up into its input.
  always begin : long_hold
    int holds_served;
    @(posedge clk_i);
    if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      sink_held <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      sink_held <= 1'b0;
    end
  end

  // Watchdog: a run with no handshake on any channel for too long is hung.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("[%0t] no handshake for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_req(input logic cmd, input logic [ValW-1:0] value);
    request_t req;
    req.cmd = cmd;
    req.value = value;
    pending_reqs = {pending_reqs, req};
  endfunction

  // mostly full-range values, some corners, some small values for ties
  function automatic logic [ValW-1:0] draw_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'd99999999;
        3: return 32'd99999998;
        4: return 32'hffff_ffff;
        default: return '0;
      endcase
    end
    if (sel < 3) return $urandom_range(8) - 4;
    return $urandom;
  endfunction

  // Leaves valid high on return so back-to-back writes need no drop in between;
  // the caller lowers it after the last one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ROWS) rows_reg = data;
    else if (idx == REG_COLS) cols_reg = data;
  endtask

  // sender pause: nothing queued, nothing in flight, nothing owed
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid_i || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int made, burst, cap, shape;
    for (int i = 0; i < GridRows * GridCols; i++) begin
      grid[i].full = 1'b0;
      grid[i].val = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, full 8x8 region: pop on empty, corner values, repeated values,
    // then drain past empty.
    push_req(CMD_EXTRACT, $urandom);
    push_req(CMD_INSERT, 32'h8000_0000);
    push_req(CMD_INSERT, 32'h7fff_ffff);
    push_req(CMD_INSERT, 32'd99999999);
    push_req(CMD_INSERT, 32'd99999998);
    push_req(CMD_INSERT, 32'd0);
    push_req(CMD_INSERT, 32'hffff_ffff);
    repeat (3) push_req(CMD_INSERT, 32'd7);
    repeat (10) push_req(CMD_EXTRACT, $urandom);
    wait_quiet();

    // Directed, 1x2 region: fill, refuse when full, drain past empty.
    write_reg(REG_ROWS, 4'd1);
    write_reg(REG_COLS, 4'd2);
    cfg_valid_i <= 1'b0;
    settings_used++;
    push_req(CMD_INSERT, 32'd3);
    push_req(CMD_INSERT, 32'd1);
    push_req(CMD_INSERT, 32'd2);
    repeat (3) push_req(CMD_EXTRACT, $urandom);

    // Random phases, each writing a region setting; contents carry over across
    // resizes on purpose.
    for (int p = 0; p < NumPhases; p++) begin
      wait_quiet();
      if (p == NumPhases / 3) begin
        src_idle_pct <= 61;
        sink_idle_pct <= 9;
      end else if (p == 2 * NumPhases / 3) begin
        src_idle_pct <= 0;
        sink_idle_pct <= 0;
      end
      write_reg(REG_ROWS, rows_plan[p]);
      write_reg(REG_COLS, cols_plan[p]);
      if (p % 4 == 3) begin
        write_reg(REG_UNUSED_A, DimW'($urandom));
        write_reg(REG_UNUSED_B, DimW'($urandom));
      end
      cfg_valid_i <= 1'b0;
      settings_used++;

      cap = region_span(rows_plan[p], GridRows) * region_span(cols_plan[p], GridCols);
      made = 0;
      while (made < ItemsPerPhase) begin
        shape = $urandom_range(9);
        if (shape < 6) begin
          // fill then drain, overshooting both ends now and then
          burst = $urandom_range(cap + 2, 1);
          repeat (burst) push_req(CMD_INSERT, draw_value());
          made += burst;
          burst = $urandom_range(cap + 2, 1);
          repeat (burst) push_req(CMD_EXTRACT, $urandom);
          made += burst;
        end else if (shape < 9) begin
          burst = $urandom_range(12, 1);
          repeat (burst) push_req(1'($urandom_range(1)), draw_value());
          made += burst;
        end else begin
          // near-equal values to exercise tie handling in both sifts
          burst = $urandom_range(10, 1);
          repeat (burst) push_req(CMD_INSERT, $urandom_range(2));
          made += burst;
        end
      end
      if (p == 2 * NumPhases / 3 || p == NumPhases - 1) hold_requests <= hold_requests + 1;
    end

    wait_quiet();
    if (expected_replies.size() != 0) mismatches += expected_replies.size();
    $display("Ran %0d requests over %0d region settings: %0d stored, %0d refused as full,",
             inserts_kept + inserts_refused + mins_taken + empty_pops, settings_used,
             inserts_kept, inserts_refused);
    $display("%0d minimums taken, %0d pops of an empty tableau, %0d response errors.",
             mins_taken, empty_pops, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
